[rtl/cdad_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_pkg
// Shared widths, codes, controller types and calendar helper functions for
// the date add-days unit.
// ----------------------------------------------------------------------------
package cdad_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 2;
   localparam int MOD400_W = 9;
   localparam int YLEN_W   = 9;
   localparam int STEP_W   = 6;

   // year / 400 by reciprocal: exact for every 14-bit year
   localparam int DIV400_SHIFT = 24;
   localparam int RECIP_W      = 16;
   localparam int PROD_W       = YEAR_W + RECIP_W;
   localparam int QUOT_W       = PROD_W - DIV400_SHIFT;
   localparam logic [RECIP_W-1:0] DIV400_RECIP = 16'd41944;

   localparam logic [YEAR_W-1:0]   YEAR_MAX    = 14'd9999;
   localparam logic [YEAR_W-1:0]   LEAP_CYCLE  = 14'd400;
   localparam logic [MONTH_W-1:0]  MONTH_JAN   = 4'd1;
   localparam logic [MONTH_W-1:0]  MONTH_FEB   = 4'd2;
   localparam logic [MONTH_W-1:0]  MONTH_DEC   = 4'd12;
   localparam logic [DAY_W-1:0]    DAY_FIRST   = 5'd1;
   localparam logic [MOD400_W-1:0] MOD400_LAST = 9'd399;
   localparam logic [MOD400_W-1:0] CENTURY_1   = 9'd100;
   localparam logic [MOD400_W-1:0] CENTURY_2   = 9'd200;
   localparam logic [MOD400_W-1:0] CENTURY_3   = 9'd300;
   localparam logic [YLEN_W-1:0]   YEAR_DAYS   = 9'd365;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_CHECK,
      ST_STEP,
      ST_FINISH
   } state_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_DATE = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_code_type;

   typedef struct packed {
      logic load;
      logic calc_mod;
      logic check;
      logic step;
      logic write_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic date_bad;
      logic step_done;
      logic out_free;
   } ctrl_sts_type;

   // leap from the two low year bits and the year modulo 400
   function automatic logic is_leap(logic [1:0] year_low, logic [MOD400_W-1:0] mod400);
      return (year_low == 2'd0) && (mod400 != CENTURY_1) &&
             (mod400 != CENTURY_2) && (mod400 != CENTURY_3);
   endfunction

   function automatic logic [DAY_W-1:0] days_in_month(logic [MONTH_W-1:0] month,
                                                      logic leap);
      logic [DAY_W-1:0] len;
      unique case (month)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

[rtl/cdad_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_req_if
// Request channel: starting date and day count with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cdad_req_if;
   import cdad_pkg::*;

   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  in_year;
   logic [MONTH_W-1:0] in_month;
   logic [DAY_W-1:0]   in_day;
   logic [COUNT_W-1:0] days_to_add;

   modport source (output valid, output in_year, output in_month, output in_day,
                   output days_to_add, input ready);
   modport sink   (input valid, input in_year, input in_month, input in_day,
                   input days_to_add, output ready);
endinterface

[rtl/cdad_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_rsp_if
// Response channel: resulting date and status with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cdad_rsp_if;
   import cdad_pkg::*;

   logic                valid;
   logic                ready;
   logic [YEAR_W-1:0]   out_year;
   logic [MONTH_W-1:0]  out_month;
   logic [DAY_W-1:0]    out_day;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output out_year, output out_month, output out_day,
                   output status, input ready);
   modport sink   (input valid, input out_year, input out_month, input out_day,
                   input status, output ready);
endinterface

[rtl/cdad_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_ctrl
// Sequencer: load, year modulo, date check, carry steps, result write.
// ----------------------------------------------------------------------------
module cdad_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output cdad_pkg::ctrl_cmd_type cmd,
   input  cdad_pkg::ctrl_sts_type sts
);
   import cdad_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.calc_mod = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.date_bad ? ST_FINISH : ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (sts.step_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.write_out = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/cdad_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_datapath
// Date registers, leap tracking, year/month carry step and result register.
// ----------------------------------------------------------------------------
module cdad_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  cdad_pkg::ctrl_cmd_type            cmd,
   output cdad_pkg::ctrl_sts_type            sts,
   input  logic [cdad_pkg::YEAR_W-1:0]       req_year,
   input  logic [cdad_pkg::MONTH_W-1:0]      req_month,
   input  logic [cdad_pkg::DAY_W-1:0]        req_day,
   input  logic [cdad_pkg::COUNT_W-1:0]      req_days,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [cdad_pkg::YEAR_W-1:0]       rsp_year,
   output logic [cdad_pkg::MONTH_W-1:0]      rsp_month,
   output logic [cdad_pkg::DAY_W-1:0]        rsp_day,
   output logic [cdad_pkg::STATUS_W-1:0]     rsp_status
);
   import cdad_pkg::*;

   logic [YEAR_W-1:0]    year_ff, year_in;
   logic [MONTH_W-1:0]   month_ff, month_in;
   logic [DAY_W-1:0]     day_ff, day_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [MOD400_W-1:0]  mod400_ff, mod400_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   status_code_type      code_ff, code_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [YEAR_W-1:0]    rsp_year_ff, rsp_year_in;
   logic [MONTH_W-1:0]   rsp_month_ff, rsp_month_in;
   logic [DAY_W-1:0]     rsp_day_ff, rsp_day_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic [QUOT_W-1:0]    quot;
   logic [YEAR_W-1:0]    quot_scaled;
   logic [YEAR_W-1:0]    mod_full;
   logic                 leap_cur, leap_next;
   logic [DAY_W-1:0]     month_len;
   logic [STEP_W-1:0]    to_next;
   logic [YEAR_W-1:0]    year_inc;
   logic [MOD400_W-1:0]  mod400_inc;
   logic [YLEN_W-1:0]    year_len;
   logic                 fits, jump, at_dec, overflow, result_ok;

   // calendar terms of the current position
   always_comb begin
      quot        = prod_ff[PROD_W-1:DIV400_SHIFT];
      quot_scaled = YEAR_W'(quot) * LEAP_CYCLE;
      mod_full    = year_ff - quot_scaled;

      leap_cur   = is_leap(year_ff[1:0], mod400_ff);
      month_len  = days_in_month(month_ff, leap_cur);
      to_next    = {1'b0, month_len} - {1'b0, day_ff} + STEP_W'(1);
      year_inc   = year_ff + YEAR_W'(1);
      mod400_inc = (mod400_ff == MOD400_LAST) ? '0 : mod400_ff + MOD400_W'(1);
      leap_next  = is_leap(year_inc[1:0], mod400_inc);
      // first of this month to first of the same month next year
      year_len   = YEAR_DAYS + YLEN_W'((month_ff <= MONTH_FEB) ? leap_cur : leap_next);

      fits     = rem_ff < COUNT_W'(to_next);
      jump     = (day_ff == DAY_FIRST) && (rem_ff >= COUNT_W'(year_len)) &&
                 (year_ff < YEAR_MAX);
      at_dec   = (month_ff == MONTH_DEC);
      overflow = !fits && !jump && at_dec && (year_ff >= YEAR_MAX);

      sts.date_bad  = (year_ff == '0) || (year_ff > YEAR_MAX) || (month_ff == '0) ||
                      (month_ff > MONTH_DEC) || (day_ff == '0) || (day_ff > month_len);
      sts.step_done = fits || overflow;
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      rem_in    = rem_ff;
      mod400_in = mod400_ff;
      prod_in   = prod_ff;
      code_in   = code_ff;
      if (cmd.load) begin
         year_in  = req_year;
         month_in = req_month;
         day_in   = req_day;
         rem_in   = req_days;
         prod_in  = PROD_W'(req_year) * PROD_W'(DIV400_RECIP);
      end
      if (cmd.calc_mod) begin
         mod400_in = mod_full[MOD400_W-1:0];
      end
      if (cmd.check) begin
         code_in = sts.date_bad ? STATUS_BAD_DATE : STATUS_OK;
      end
      if (cmd.step) begin
         priority if (fits) begin
            day_in = day_ff + DAY_W'(rem_ff);
         end else if (jump) begin
            year_in   = year_inc;
            mod400_in = mod400_inc;
            rem_in    = rem_ff - COUNT_W'(year_len);
         end else if (overflow) begin
            code_in = STATUS_OVERFLOW;
         end else begin
            rem_in = rem_ff - COUNT_W'(to_next);
            day_in = DAY_FIRST;
            if (at_dec) begin
               month_in  = MONTH_JAN;
               year_in   = year_inc;
               mod400_in = mod400_inc;
            end else begin
               month_in = month_ff + MONTH_W'(1);
            end
         end
      end
   end

   // output register
   always_comb begin
      result_ok     = (code_ff == STATUS_OK);
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_day_in    = rsp_day_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (cmd.write_out) begin
         rsp_year_in   = result_ok ? year_ff : '0;
         rsp_month_in  = result_ok ? month_ff : '0;
         rsp_day_in    = result_ok ? day_ff : '0;
         rsp_status_in = code_ff;
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      year_ff       <= year_in;
      month_ff      <= month_in;
      day_ff        <= day_in;
      rem_ff        <= rem_in;
      mod400_ff     <= mod400_in;
      prod_ff       <= prod_in;
      code_ff       <= code_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_year   = rsp_year_ff;
   assign rsp_month  = rsp_month_ff;
   assign rsp_day    = rsp_day_ff;
   assign rsp_status = rsp_status_ff;

   a_mod400_range: assert property (@(posedge clock) disable iff (reset)
      cmd.calc_mod |=> (mod400_ff < LEAP_CYCLE[MOD400_W-1:0]))
      else $error("year modulo 400 out of range");

   a_step_date_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC) &&
                   (day_ff >= DAY_FIRST) && (day_ff <= month_len) && (year_ff <= YEAR_MAX))
      else $error("carry step on an invalid date");

   a_step_progress: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && !sts.step_done) |=> (rem_ff < $past(rem_ff)))
      else $error("carry step did not consume days");

   a_write_ok_fields: assert property (@(posedge clock) disable iff (reset)
      (cmd.write_out && !result_ok) |=> (rsp_year_ff == '0) && (rsp_day_ff == '0))
      else $error("error result carries a date");

endmodule

[rtl/calendar_date_add_days_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_add_days_unit
// Gregorian date plus a non-negative day count, with date and range checks.
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one start date (year, month, day) and a day count per
//   transaction; rsp_chan returns the resulting date and a status code
//   (ok, invalid input date, year past 9999, date fields zero on error)
//   one transaction is in flight at a time: req_chan.ready is high only
//   while the sequencer is idle
//   after acceptance the sequencer computes the year modulo 400, checks
//   the date, runs the carry steps (none for an invalid date) and writes
//   the output register; it then returns to idle to take the next request
//   carry steps: one to reach the first of the next month, then one per
//   whole year jumped and one per remaining month, plus a final step;
//   the worst count takes about 191 steps, each one a pass through the
//   shared year/month carry unit
//   the result sits in an output register; a stalled receiver only holds
//   the finished transaction there, the next request is still accepted and
//   worked on, and waits for the register to free before it is written
//   reset returns the sequencer to idle and drops any pending result
// ----------------------------------------------------------------------------
module calendar_date_add_days_unit (
   input  logic  clock,
   input  logic  reset,
   cdad_req_if.sink   req_chan,
   cdad_rsp_if.source rsp_chan
);
   import cdad_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;
   logic         req_ready;

   // sequencer
   cdad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   assign req_chan.ready = req_ready;

   // date registers, carry unit and output register
   cdad_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_year   (req_chan.in_year),
      .req_month  (req_chan.in_month),
      .req_day    (req_chan.in_day),
      .req_days   (req_chan.days_to_add),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_year   (rsp_chan.out_year),
      .rsp_month  (rsp_chan.out_month),
      .rsp_day    (rsp_chan.out_day),
      .rsp_status (rsp_chan.status)
   );

endmodule
